>>> hdl/spectrum_band_bars_with_peak_fall_top_defines.svh
// ----------------------------------------------------------------------------
// spectrum band bars assertion macros
// concurrent assertion helpers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_BARS_WITH_PEAK_FALL_TOP_DEFINES_SVH
`define SPECTRUM_BAND_BARS_WITH_PEAK_FALL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SBB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sbb assertion failed");
`define SBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbb assertion failed");
`else
`define SBB_ASSERT(label, prop)
`define SBB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// shared constants, types and the bin to band table
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int COLUMNS    = 30;
   localparam int ROWS       = 32;
   localparam int FFT_POINTS = 64;

   localparam int BIN_W      = 5;
   localparam int MAG_W      = 18;
   localparam int SUM_W      = 20;
   localparam int COL_W      = 5;
   localparam int BAR_W      = 5;
   localparam int PEAK_W     = 6;
   localparam int DIV_W      = 10;
   localparam int EDGE_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int STEP_W     = $clog2(BAR_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int BIN_LO = 2;
   localparam int BIN_HI = FFT_POINTS / 2 - 1;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam logic signed [PEAK_W-1:0] PEAK_FLOOR = -6'sd1;
   localparam logic signed [PEAK_W-1:0] PEAK_TOP   =
      PEAK_W'((ROWS - 1 > 31) ? 31 : ROWS - 1);

   localparam logic [MAG_W-1:0] NOISE_THRESHOLD_RST = MAG_W'(200);
   localparam logic [DIV_W-1:0] BAR_DIVISOR_RST     = DIV_W'(70);
   localparam logic [BAR_W-1:0] BAR_LIMIT_RST       = BAR_W'(21);

   localparam logic [EDGE_W-1:0] BAND_EDGE [COLUMNS] = '{
      6'd2,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
      6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
      6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_THRESHOLD = 2'd0,
      CSR_BAR_DIVISOR     = 2'd1,
      CSR_BAR_LIMIT       = 2'd2,
      CSR_PEAK_ENABLE     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACC,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [MAG_W-1:0] noise_threshold;
      logic [DIV_W-1:0] bar_divisor;
      logic [BAR_W-1:0] bar_limit;
      logic             peak_enable;
   } cfg_type;

   typedef struct packed {
      logic             counts;
      logic [COL_W-1:0] band;
      logic [MAG_W-1:0] magnitude;
      logic             frame_end;
   } item_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // first band whose edge is at or above the bin
   function automatic logic [COL_W-1:0] band_of(input logic [BIN_W-1:0] bin);
      logic [COL_W-1:0] idx;
      idx = '0;
      for (int b = COLUMNS - 1; b >= 0; b--) begin
         if (EDGE_W'(bin) <= BAND_EDGE[b]) idx = COL_W'(b);
      end
      return idx;
   endfunction

endpackage

>>> hdl/sbb_front.sv
// ----------------------------------------------------------------------------
// sbb_front
// takes bin beats and classifies them: band, noise gate, frame end
// ----------------------------------------------------------------------------
module sbb_front import sbb_pkg::*; (
   input  logic             start,
   input  logic             full_i,
   input  logic [BIN_W-1:0] req_bin_index,
   input  logic [MAG_W-1:0] req_magnitude,
   input  logic             req_frame_end,
   input  cfg_type          cfg_i,
   output logic             push_o,
   output item_type         item_o
);

   logic in_range;

   assign in_range = (EDGE_W'(req_bin_index) >= EDGE_W'(BIN_LO)) &&
                     (EDGE_W'(req_bin_index) <= EDGE_W'(BIN_HI));

   assign push_o = start && !full_i;

   always_comb begin
      item_o.counts    = in_range && (req_magnitude > cfg_i.noise_threshold);
      item_o.band      = band_of(req_bin_index);
      item_o.magnitude = req_magnitude;
      item_o.frame_end = req_frame_end;
   end

endmodule

>>> hdl/sbb_queue.sv
// ----------------------------------------------------------------------------
// sbb_queue
// short fifo of classified bins between front and back
// ----------------------------------------------------------------------------
module sbb_queue import sbb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_ctrl_type ctrl_i,
   input  item_type       item_i,
   output item_type       item_o,
   output queue_stat_type stat_o
);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign stat_o.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat_o.empty = (count_ff == '0);
   assign do_push      = ctrl_i.push && !stat_o.full;
   assign do_pop       = ctrl_i.pop && !stat_o.empty;
   assign item_o       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= item_i;
   end

endmodule

>>> hdl/sbb_back.sv
// ----------------------------------------------------------------------------
// sbb_back
// band accumulation, per column divide, clamp and falling peak, result beats
// ----------------------------------------------------------------------------
`include "spectrum_band_bars_with_peak_fall_top_defines.svh"

module sbb_back import sbb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg_i,
   input  logic                     empty_i,
   input  item_type                 item_i,
   output logic                     pop_o,
   output logic                     rsp_valid,
   output logic [COL_W-1:0]         rsp_column,
   output logic [BAR_W-1:0]         rsp_bar_height,
   output logic signed [PEAK_W-1:0] rsp_peak_height,
   output logic                     rsp_last_column
);

   back_state_type            state_ff, state_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [SUM_W-1:0]          rem_ff, rem_in;
   logic [BAR_W-1:0]          quot_ff, quot_in;
   logic                      ovf_ff, ovf_in;
   logic [SUM_W-1:0]          sums_ff [COLUMNS];
   logic signed [PEAK_W-1:0]  peaks_ff [COLUMNS];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]          rsp_column_ff;
   logic [BAR_W-1:0]          rsp_bar_ff, rsp_bar_in;
   logic signed [PEAK_W-1:0]  rsp_peak_ff;
   logic                      rsp_last_ff;

   logic [COL_W-1:0]          sum_addr;
   logic [SUM_W-1:0]          sum_rd;
   logic [SUM_W:0]            sum_add;
   logic [SUM_W-1:0]          sum_sat;
   logic                      acc_we, clr_we, peak_we;
   logic [DIV_W-1:0]          div_eff;
   logic [SUM_W-1:0]          trial;
   logic                      trial_ge;
   logic signed [PEAK_W-1:0]  peak_rd, peak_new, bar_ext;
   logic                      last_col;

   assign pop_o    = (state_ff == ST_ACC) && !empty_i;
   assign last_col = (col_ff == COL_W'(COLUMNS - 1));
   assign div_eff  = (cfg_i.bar_divisor == '0) ? DIV_W'(1) : cfg_i.bar_divisor;

   assign sum_addr = (state_ff == ST_ACC) ? item_i.band : col_ff;
   assign sum_rd   = sums_ff[sum_addr];
   assign sum_add  = {1'b0, sum_rd} + (SUM_W + 1)'(item_i.magnitude);
   assign sum_sat  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

   assign trial    = SUM_W'(div_eff) << step_ff;
   assign trial_ge = (rem_ff >= trial);

   assign peak_rd  = peaks_ff[col_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACC: begin
            if (pop_o && item_i.frame_end) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = last_col ? ST_ACC : ST_LOAD;
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      col_in       = col_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      ovf_in       = ovf_ff;
      acc_we       = 1'b0;
      clr_we       = 1'b0;
      peak_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_bar_in   = quot_ff;
      bar_ext      = '0;
      peak_new     = peak_rd;
      case (state_ff)
         ST_ACC: begin
            acc_we = pop_o && item_i.counts;
            col_in = '0;
         end
         ST_LOAD: begin
            clr_we  = 1'b1;
            rem_in  = sum_rd;
            ovf_in  = (sum_rd >= (SUM_W'(div_eff) << BAR_W));
            quot_in = '0;
            step_in = STEP_W'(BAR_W - 1);
         end
         ST_DIV: begin
            if (trial_ge) rem_in = rem_ff - trial;
            quot_in = {quot_ff[BAR_W-2:0], trial_ge};
            if (step_ff != '0) step_in = step_ff - 1'b1;
         end
         ST_EMIT: begin
            if (ovf_ff || (quot_ff > cfg_i.bar_limit)) rsp_bar_in = cfg_i.bar_limit;
            else rsp_bar_in = quot_ff;
            bar_ext = signed'({1'b0, rsp_bar_in});
            if (cfg_i.peak_enable) begin
               if (bar_ext > peak_rd) peak_new = bar_ext;
               else if (peak_rd > PEAK_FLOOR) peak_new = peak_rd - 6'sd1;
            end
            peak_we      = 1'b1;
            rsp_valid_in = 1'b1;
            col_in       = last_col ? '0 : col_ff + 1'b1;
         end
         default: begin
            col_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         col_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      if (rsp_valid_in) begin
         rsp_column_ff <= col_ff;
         rsp_bar_ff    <= rsp_bar_in;
         rsp_peak_ff   <= peak_new;
         rsp_last_ff   <= last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) sums_ff[c] <= '0;
      end else if (acc_we) begin
         sums_ff[item_i.band] <= sum_sat;
      end else if (clr_we) begin
         sums_ff[col_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) begin
            peaks_ff[c] <= (c == 1) ? PEAK_TOP : PEAK_FLOOR;
         end
      end else if (peak_we) begin
         peaks_ff[col_ff] <= peak_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_bar_height  = rsp_bar_ff;
   assign rsp_peak_height = rsp_peak_ff;
   assign rsp_last_column = rsp_last_ff;

   `SBB_ASSERT_NEXT(a_emit_gives_beat, state_ff == ST_EMIT, rsp_valid_ff)
   `SBB_ASSERT(a_last_beat_ends_sweep, rsp_valid_ff && rsp_last_ff |-> state_ff == ST_ACC)
   `SBB_ASSERT(a_sweep_column_range, state_ff != ST_ACC |-> col_ff < COL_W'(COLUMNS))
   `SBB_ASSERT(a_div_step_range, state_ff == ST_DIV |-> step_ff < STEP_W'(BAR_W))

endmodule

>>> hdl/spectrum_band_bars_with_peak_fall_top.sv
// ----------------------------------------------------------------------------
// spectrum_band_bars_with_peak_fall_top
// spectrum bars with falling peaks from one frame of fft magnitude bins
// ----------------------------------------------------------------------------
// Bins are taken one per cycle while busy is low; busy rises only when the
// four-beat queue in front of the accumulator is full. A bin leaves the queue
// and is added to its band in the same cycle. The bin that carries frame_end
// starts a sweep over the 30 columns: each column loads and clears its band sum,
// runs a shared restoring divider that makes one quotient bit a cycle, then does
// the clamp, the peak update and the result beat, so a frame produces 30 result
// beats. rsp_valid is high for one cycle per beat and cannot be held off. Bins
// sent during a sweep wait in the queue, and busy stays high once it fills,
// until the sweep ends. Configuration writes take effect at once and belong to
// idle periods.
// ----------------------------------------------------------------------------
module spectrum_band_bars_with_peak_fall_top import sbb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [BIN_W-1:0]         req_bin_index,
   input  logic [MAG_W-1:0]         req_magnitude,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   output logic [COL_W-1:0]         rsp_column,
   output logic [BAR_W-1:0]         rsp_bar_height,
   output logic signed [PEAK_W-1:0] rsp_peak_height,
   output logic                     rsp_last_column,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type        cfg_ff, cfg_in;
   queue_ctrl_type qctrl;
   queue_stat_type qstat;
   item_type       front_item, queue_item;
   logic           push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_NOISE_THRESHOLD: cfg_in.noise_threshold = csr_data[MAG_W-1:0];
            CSR_BAR_DIVISOR:     cfg_in.bar_divisor     = csr_data[DIV_W-1:0];
            CSR_BAR_LIMIT:       cfg_in.bar_limit       = csr_data[BAR_W-1:0];
            CSR_PEAK_ENABLE:     cfg_in.peak_enable     = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_threshold <= NOISE_THRESHOLD_RST;
         cfg_ff.bar_divisor     <= BAR_DIVISOR_RST;
         cfg_ff.bar_limit       <= BAR_LIMIT_RST;
         cfg_ff.peak_enable     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy       = qstat.full;
   assign qctrl.push = push;
   assign qctrl.pop  = pop;

   sbb_front u_front (
      .start         (start),
      .full_i        (qstat.full),
      .req_bin_index (req_bin_index),
      .req_magnitude (req_magnitude),
      .req_frame_end (req_frame_end),
      .cfg_i         (cfg_ff),
      .push_o        (push),
      .item_o        (front_item)
   );

   sbb_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (qctrl),
      .item_i (front_item),
      .item_o (queue_item),
      .stat_o (qstat)
   );

   sbb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_i           (cfg_ff),
      .empty_i         (qstat.empty),
      .item_i          (queue_item),
      .pop_o           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_column      (rsp_column),
      .rsp_bar_height  (rsp_bar_height),
      .rsp_peak_height (rsp_peak_height),
      .rsp_last_column (rsp_last_column)
   );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// spectrum band bars testbench
// drives frames of fft bins into the band bar block, predicts the column
// beats of each frame end with a scoreboard and checks every field of them
// ----------------------------------------------------------------------------
module tb import sbb_pkg::*; ();

   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_LIMIT    = 5000;
   localparam int MAG_MAX       = (1 << MAG_W) - 1;
   localparam int SUM_SAT       = (1 << SUM_W) - 1;

   typedef struct packed {
      logic [COL_W-1:0]         column;
      logic [BAR_W-1:0]         bar_height;
      logic signed [PEAK_W-1:0] peak_height;
      logic                     last_column;
   } column_beat_type;

   class band_bar_scoreboard;
      int unsigned     noise_thr;
      int unsigned     divisor;
      int unsigned     bar_cap;
      bit              peaks_on;
      int unsigned     band_sum [COLUMNS];
      int              peak_row [COLUMNS];
      column_beat_type pending_beats [$];
      int              errors;

      function new();
         noise_thr = 200;
         divisor   = 70;
         bar_cap   = 21;
         peaks_on  = 1'b1;
         errors    = 0;
         foreach (band_sum[c]) begin
            band_sum[c] = 0;
            peak_row[c] = -1;
         end
         if (COLUMNS > 1) peak_row[1] = (ROWS - 1 > 31) ? 31 : ROWS - 1;
      endfunction

      function void write_reg(csr_index_type idx, int unsigned value);
         case (idx)
            CSR_NOISE_THRESHOLD: noise_thr = value & MAG_MAX;
            CSR_BAR_DIVISOR:     divisor   = value & ((1 << DIV_W) - 1);
            CSR_BAR_LIMIT:       bar_cap   = value & ((1 << BAR_W) - 1);
            CSR_PEAK_ENABLE:     peaks_on  = value[0];
            default: ;
         endcase
      endfunction

      // accumulate one bin and, at frame end, queue the column beats
      function void note_bin(int unsigned bin, int unsigned mag, bit frame_end);
         int unsigned s;
         int unsigned div;
         int unsigned bar;
         column_beat_type beat;
         if (bin >= BIN_LO && bin <= BIN_HI && mag > noise_thr) begin
            for (int b = 0; b < COLUMNS; b++) begin
               if (bin <= BAND_EDGE[b]) begin
                  s = band_sum[b] + mag;
                  band_sum[b] = (s > SUM_SAT) ? SUM_SAT : s;
                  break;
               end
            end
         end
         if (!frame_end) return;
         div = (divisor == 0) ? 1 : divisor;
         for (int c = 0; c < COLUMNS; c++) begin
            bar = band_sum[c] / div;
            if (bar > bar_cap) bar = bar_cap;
            if (peaks_on) begin
               if (int'(bar) > peak_row[c]) peak_row[c] = bar;
               else if (peak_row[c] > -1) peak_row[c]--;
            end
            beat.column      = COL_W'(c);
            beat.bar_height  = BAR_W'(bar);
            beat.peak_height = PEAK_W'(peak_row[c]);
            beat.last_column = (c == COLUMNS - 1);
            pending_beats.push_back(beat);
            band_sum[c] = 0;
         end
      endfunction

      function void check_beat(column_beat_type got);
         column_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected beat for column %0d", got.column);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.column !== want.column) begin
            $error("column expected %0d got %0d", want.column, got.column);
            errors++;
         end
         if (got.bar_height !== want.bar_height) begin
            $error("bar_height expected %0d got %0d", want.bar_height, got.bar_height);
            errors++;
         end
         if (got.peak_height !== want.peak_height) begin
            $error("peak_height expected %0d got %0d", want.peak_height,
                   got.peak_height);
            errors++;
         end
         if (got.last_column !== want.last_column) begin
            $error("last_column expected %0d got %0d", want.last_column,
                   got.last_column);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [BIN_W-1:0]         req_bin_index = '0;
   logic [MAG_W-1:0]         req_magnitude = '0;
   logic                     req_frame_end = 1'b0;
   logic                     rsp_valid;
   logic [COL_W-1:0]         rsp_column;
   logic [BAR_W-1:0]         rsp_bar_height;
   logic signed [PEAK_W-1:0] rsp_peak_height;
   logic                     rsp_last_column;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   band_bar_scoreboard sb = new();
   int unsigned        sent_bins = 0;
   int unsigned        quiet_cycles = 0;
   bit                 no_idle = 1'b0;

   spectrum_band_bars_with_peak_fall_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_bin_index   (req_bin_index),
      .req_magnitude   (req_magnitude),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_column      (rsp_column),
      .rsp_bar_height  (rsp_bar_height),
      .rsp_peak_height (rsp_peak_height),
      .rsp_last_column (rsp_last_column),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_beat('{rsp_column, rsp_bar_height, rsp_peak_height, rsp_last_column});
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_bin(int unsigned bin, int unsigned mag, bit frame_end);
      @(negedge clock);
      start         <= 1'b1;
      req_bin_index <= BIN_W'(bin);
      req_magnitude <= MAG_W'(mag);
      req_frame_end <= frame_end;
      do @(posedge clock); while (busy);
      sb.note_bin(bin, mag, frame_end);
      sent_bins++;
   endtask

   task automatic idle_gap();
      int unsigned sel;
      int unsigned gap;
      sel = $urandom_range(0, 99);
      if (no_idle || sel < 50) gap = 0;
      else if (sel < 85) gap = $urandom_range(1, 3);
      else if (sel < 95) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and let every queued beat and bin drain out
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_beats.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_setting(int unsigned thr, int unsigned div, int unsigned cap,
                                bit peaks);
      write_reg(CSR_NOISE_THRESHOLD, thr);
      write_reg(CSR_BAR_DIVISOR, div);
      write_reg(CSR_BAR_LIMIT, cap);
      write_reg(CSR_PEAK_ENABLE, peaks);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic int unsigned pick_bin();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1);
      return $urandom_range(BIN_LO, BIN_HI);
   endfunction

   function automatic int unsigned pick_mag();
      int unsigned sel;
      int unsigned lo;
      int unsigned hi;
      sel = $urandom_range(0, 9);
      lo  = (sb.noise_thr > 2) ? sb.noise_thr - 2 : 0;
      hi  = (sb.noise_thr + 2 > MAG_MAX) ? MAG_MAX : sb.noise_thr + 2;
      if (sel < 6) return $urandom_range(0, 3000);
      if (sel < 8) return $urandom_range(0, MAG_MAX);
      return $urandom_range(lo, hi);
   endfunction

   task automatic send_frame();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int k = 0; k <= n; k++) begin
         send_bin(pick_bin(), pick_mag(), k == n);
         idle_gap();
      end
   endtask

   task automatic run_bins(int unsigned count);
      int unsigned first;
      first = sent_bins;
      while (sent_bins - first < count) send_frame();
      settle();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // out of range bins, threshold edge, saturated band, empty columns
      send_bin(0, MAG_MAX, 1'b0);
      send_bin(1, MAG_MAX, 1'b0);
      send_bin(2, 200, 1'b0);
      send_bin(2, 201, 1'b0);
      idle_gap();
      repeat (5) send_bin(31, MAG_MAX, 1'b0);
      send_bin(3, 0, 1'b0);
      send_bin(4, 7000, 1'b0);
      send_bin(16, 1400, 1'b1);
      idle_gap();
      // peaks falling over quiet frames
      send_bin(5, 3000, 1'b1);
      send_bin(31, 0, 1'b1);
      send_bin(0, 1000, 1'b1);
      send_bin(1, 5000, 1'b1);
      send_bin(10, 131072, 1'b1);
      send_bin(9, 262000, 1'b0);
      send_bin(9, 262000, 1'b0);
      send_bin(9, 262000, 1'b0);
      send_bin(9, 262000, 1'b0);
      send_bin(9, 262000, 1'b1);
      settle();

      no_idle = 1'b1;
      apply_setting(0, 1, 31, 1'b1);
      run_bins(50);
      no_idle = 1'b0;

      apply_setting(MAG_MAX, (1 << DIV_W) - 1, 0, 1'b0);
      run_bins(25);

      apply_setting(100, 0, 31, 1'b1);
      run_bins(40);

      apply_setting(200, 70, 21, 1'b0);
      run_bins(30);

      repeat (3) begin
         apply_setting($urandom_range(0, 3000),
                       ($urandom_range(0, 7) == 0) ? (1 << DIV_W) - 1 : $urandom_range(1, 300),
                       $urandom_range(0, 31), $urandom_range(0, 1));
         run_bins(35);
      end

      if (sb.pending_beats.size() > 0) begin
         $error("%0d expected beats never arrived", sb.pending_beats.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
